// ----- hw/rtl/rgb24_to_yuv420_bt601_unit_macros.svh -----
// Assertion helpers shared by the converter modules.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef RGB24_TO_YUV420_BT601_UNIT_MACROS_SVH
`define RGB24_TO_YUV420_BT601_UNIT_MACROS_SVH

// Same-cycle implication.
`define RYUV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RYUV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ryuv_pkg.sv -----
`default_nettype none

package ryuv_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W = 13;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  // Size register indexes on the configuration port
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Q16 BT.601 coefficients
  localparam logic signed [25:0] COEF_YR = 26'sd19595;
  localparam logic signed [25:0] COEF_YG = 26'sd38470;
  localparam logic signed [25:0] COEF_YB = 26'sd7471;
  localparam logic signed [25:0] COEF_UR = -26'sd11076;
  localparam logic signed [25:0] COEF_UG = -26'sd21692;
  localparam logic signed [25:0] COEF_UB = 26'sd32768;
  localparam logic signed [25:0] COEF_VR = 26'sd32768;
  localparam logic signed [25:0] COEF_VG = -26'sd27460;
  localparam logic signed [25:0] COEF_VB = -26'sd5308;

  // one half in Q16, and 128.5 in Q16 for the chroma offset plus rounding
  localparam logic signed [25:0] ROUND_HALF  = 26'sd32768;
  localparam logic signed [25:0] CHROMA_BIAS = 26'sd8421376;

  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } ryuv_flags_t;

  // Drop the Q16 fraction and clamp to a byte.
  function automatic logic [7:0] ryuv_to_byte(input logic signed [25:0] acc);
    logic [7:0] res;
    if (acc < 0) begin
      res = 8'd0;
    end else if (acc[25:24] != 2'b00) begin
      res = 8'd255;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ryuv_scan.sv -----
`default_nettype none

`include "rgb24_to_yuv420_bt601_unit_macros.svh"

module ryuv_scan #(
  parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,
  input  logic                                advance,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_h,
  output logic                                pix_valid,
  output logic [7:0]                          pix_red,
  output logic [7:0]                          pix_green,
  output logic [7:0]                          pix_blue,
  output logic [$clog2(MAX_WIDTH)-1:0]        pix_x,
  output logic [$clog2(MAX_HEIGHT)-1:0]       pix_y,
  output ryuv_pkg::ryuv_flags_t               pix_flags
);
  import ryuv_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  logic [XB-1:0] column_count, column_next, x_cur;
  logic [YB-1:0] row_count, row_next, row_cur, y_cur;
  logic [WB-1:0] x_inc;
  logic [HB-1:0] row_inc, y_inc;
  logic          accept, wrap, last, cvalid;

  assign s_tready = !pix_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    // a counter left beyond a shrunken size restarts at zero
    x_cur   = (WB'(column_count) >= frame_w) ? '0 : column_count;
    row_cur = (HB'(row_count) >= frame_h) ? '0 : row_count;
    x_inc   = WB'(x_cur) + WB'(1);
    row_inc = HB'(row_cur) + HB'(1);
    y_cur   = YB'(frame_h - row_inc);
    y_inc   = HB'(y_cur) + HB'(1);
    wrap    = (x_inc == frame_w);
    last    = wrap && (row_inc == frame_h);
    cvalid  = !x_cur[0] && !y_cur[0] && (x_inc < frame_w) && (y_inc < frame_h);
    column_next = wrap ? '0 : XB'(x_inc);
    if (wrap) begin
      row_next = (row_inc == frame_h) ? '0 : YB'(row_inc);
    end else begin
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid    <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      pix_valid    <= 1'b1;
      column_count <= column_next;
      row_count    <= row_next;
    end else if (advance) begin
      pix_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_red                <= s_tdata[7:0];
      pix_green              <= s_tdata[15:8];
      pix_blue               <= s_tdata[23:16];
      pix_x                  <= x_cur;
      pix_y                  <= y_cur;
      pix_flags.chroma_valid <= cvalid;
      pix_flags.frame_end    <= last;
    end
  end

  `RYUV_ASSERT_NOW(a_chroma_site_even, pix_valid && pix_flags.chroma_valid, !pix_x[0] && !pix_y[0], "chroma flagged off an even site")
  `RYUV_ASSERT_NEXT(a_frame_wrap, accept && last, (column_count == '0) && (row_count == '0), "counters not cleared after last pixel")
  `RYUV_ASSERT_NEXT(a_stall_hold, pix_valid && !advance, pix_valid && $stable(pix_x) && $stable(pix_y), "held pixel lost while stalled")

endmodule

`default_nettype wire

// ----- hw/rtl/ryuv_convert.sv -----
`default_nettype none

`include "rgb24_to_yuv420_bt601_unit_macros.svh"

module ryuv_convert #(
  parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  input  logic [7:0]                          pix_red,
  input  logic [7:0]                          pix_green,
  input  logic [7:0]                          pix_blue,
  input  logic [$clog2(MAX_WIDTH)-1:0]        pix_x,
  input  logic [$clog2(MAX_HEIGHT)-1:0]       pix_y,
  input  ryuv_pkg::ryuv_flags_t               pix_flags,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_w,
  output logic                                advance,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [71:0]                         m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import ryuv_pkg::*;

  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int PW = YB + WB + 1;
  localparam int LW = (PW > 24) ? PW : 24;
  localparam int CW = (PW > 22) ? PW : 22;

  logic signed [25:0] r_s, g_s, b_s, y_acc, u_acc, v_acc;
  logic [LW-1:0]      laddr_full;
  logic [CW-1:0]      caddr_full;
  logic               take;

  logic [7:0]  luma, chroma_u, chroma_v;
  logic [23:0] luma_address;
  logic [21:0] chroma_address;
  ryuv_flags_t flags;

  assign advance = !m_tvalid || m_tready;
  assign take    = pix_valid && advance;

  always_comb begin
    r_s   = signed'(26'(pix_red));
    g_s   = signed'(26'(pix_green));
    b_s   = signed'(26'(pix_blue));
    y_acc = COEF_YR * r_s + COEF_YG * g_s + COEF_YB * b_s + ROUND_HALF;
    u_acc = COEF_UR * r_s + COEF_UG * g_s + COEF_UB * b_s + CHROMA_BIAS;
    v_acc = COEF_VR * r_s + COEF_VG * g_s + COEF_VB * b_s + CHROMA_BIAS;
    laddr_full = LW'(pix_y) * LW'(frame_w) + LW'(pix_x);
    caddr_full = CW'(pix_y >> 1) * CW'(frame_w >> 1) + CW'(pix_x >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      luma         <= ryuv_to_byte(y_acc);
      luma_address <= laddr_full[23:0];
      flags        <= pix_flags;
      if (pix_flags.chroma_valid) begin
        chroma_u       <= ryuv_to_byte(u_acc);
        chroma_v       <= ryuv_to_byte(v_acc);
        chroma_address <= caddr_full[21:0];
      end else begin
        chroma_u       <= 8'd0;
        chroma_v       <= 8'd0;
        chroma_address <= 22'd0;
      end
    end
  end

  assign m_tdata = {2'b00, chroma_address, chroma_v, chroma_u, luma_address, luma};
  assign m_tuser = flags.chroma_valid;
  assign m_tlast = flags.frame_end;

  `RYUV_ASSERT_NOW(a_chroma_zero, m_tvalid && !flags.chroma_valid, (chroma_u == 8'd0) && (chroma_v == 8'd0) && (chroma_address == 22'd0), "chroma fields not cleared")
  `RYUV_ASSERT_NOW(a_chroma_not_last, m_tvalid && flags.chroma_valid, !flags.frame_end, "chroma on last column")
  `RYUV_ASSERT_NEXT(a_take_fills, take, m_tvalid, "taken pixel did not reach output")

endmodule

`default_nettype wire

// ----- hw/rtl/rgb24_to_yuv420_bt601_unit.sv -----
`default_nettype none

// BT.601 RGB to YUV 4:2:0 converter. Feed one 24-bit RGB pixel per request in
// bitmap order (bottom image row first, each row left to right); every pixel
// returns its Q16-rounded, clamped luma and Y-plane address, and pixels on even
// image row and even column (with a right and lower neighbor inside the frame)
// also carry point-sampled U and V with offset 128 and their chroma-plane address,
// flagged on m_tuser. m_tlast marks the last pixel of a frame. The block takes one
// pixel every clock unless a stalled output holds it: a two-stage pipeline (input
// register holding the pixel and its scan position, then the result register after
// the constant-coefficient math and one address multiply per plane), and a stalled
// output only holds the pipeline while both stages are full. The user must write
// frame width and height through cfg_* only while no pixel is in flight; the block
// does not enforce this. Zero counts as one and sizes above the MAX parameters
// saturate. No memory, no clearing pass after reset.
module rgb24_to_yuv420_bt601_unit #(
  parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  // request in
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // result out
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [71:0]               m_tdata,   // luma[7:0], luma_address[31:8],
                                               // chroma_u[39:32], chroma_v[47:40],
                                               // chroma_address[69:48], zero[71:70]
  output logic                      m_tuser,   // chroma_valid[0]
  output logic                      m_tlast,   // frame_end
  // configuration writes
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ryuv_pkg::CFG_W-1:0] cfg_data
);
  import ryuv_pkg::*;

  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (WB > CFG_W) ? WB : CFG_W;
  localparam int CMPH = (HB > CFG_W) ? HB : CFG_W;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [WB-1:0]    frame_w;
  logic [HB-1:0]    frame_h;

  logic                        advance, pix_valid;
  logic [7:0]                  pix_red, pix_green, pix_blue;
  logic [$clog2(MAX_WIDTH)-1:0]  pix_x;
  logic [$clog2(MAX_HEIGHT)-1:0] pix_y;
  ryuv_flags_t                 pix_flags;

  // Register writes land immediately; the counters are left alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Size in force: zero reads as one, oversize saturates at the maximum.
  always_comb begin
    if (frame_width == '0) begin
      frame_w = WB'(1);
    end else if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      frame_w = WB'(MAX_WIDTH);
    end else begin
      frame_w = WB'(frame_width);
    end
    if (frame_height == '0) begin
      frame_h = HB'(1);
    end else if (CMPH'(frame_height) > CMPH'(MAX_HEIGHT)) begin
      frame_h = HB'(MAX_HEIGHT);
    end else begin
      frame_h = HB'(frame_height);
    end
  end

  // Stage one: scan counters and the input register.
  ryuv_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .advance   (advance),
    .frame_w   (frame_w),
    .frame_h   (frame_h),
    .pix_valid (pix_valid),
    .pix_red   (pix_red),
    .pix_green (pix_green),
    .pix_blue  (pix_blue),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_flags (pix_flags)
  );

  // Stage two: color math, plane addresses and the result register.
  ryuv_convert #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_convert (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_red   (pix_red),
    .pix_green (pix_green),
    .pix_blue  (pix_blue),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_flags (pix_flags),
    .frame_w   (frame_w),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

// Stream test of the BT.601 RGB to YUV 4:2:0 converter.
// An initial block plans the run as a series of frame-size settings: it writes
// the size registers while nothing is in flight, then queues pixel requests.
// A negedge driver presents them, a negedge sink paces the result side, and a
// posedge monitor predicts every accepted pixel and checks every result.
module testbench;

  localparam int CFG_W       = ryuv_pkg::CFG_W;
  localparam int MAX_W       = ryuv_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H       = ryuv_pkg::DEF_MAX_HEIGHT;
  localparam int RANDOM_PIX  = 700;
  localparam int QUIET_TAIL  = 120;   // last random pixels run with no idling
  localparam int LONG_HOLD   = 120;   // sink hold-off, long enough to back up the input
  localparam int STALL_LIMIT = 4000;  // cycles with no request moving on either side

  // Q16 BT.601 weights, rounding and chroma offset
  localparam int YR = 19595;
  localparam int YG = 38470;
  localparam int YB = 7471;
  localparam int UR = -11076;
  localparam int UG = -21692;
  localparam int UB = 32768;
  localparam int VR = 32768;
  localparam int VG = -27460;
  localparam int VB = -5308;
  localparam int Q16_HALF     = 32768;
  localparam int CHROMA_OFFS  = 8421376;  // 128.5 in Q16

  typedef struct packed {
    logic [7:0]  luma;
    logic [23:0] luma_addr;
    logic        chroma_valid;
    logic [7:0]  chroma_u;
    logic [7:0]  chroma_v;
    logic [21:0] chroma_addr;
    logic        frame_end;
  } yuv_result_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic [23:0]      s_tdata   = '0;
  logic             m_tready  = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = ryuv_pkg::REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  wire              s_tready;
  wire              m_tvalid;
  wire  [71:0]      m_tdata;
  wire              m_tuser;
  wire              m_tlast;

  rgb24_to_yuv420_bt601_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Pixels waiting for the driver, {blue, green, red} as on s_tdata.
  logic [23:0] pixel_q[$];
  yuv_result_t yuv_expected[$];

  // Shadow of the size registers and of the scan position.
  logic [CFG_W-1:0] width_reg  = ryuv_pkg::RESET_FRAME_WIDTH;
  logic [CFG_W-1:0] height_reg = ryuv_pkg::RESET_FRAME_HEIGHT;
  logic [11:0]      scan_col   = '0;
  logic [11:0]      scan_row   = '0;

  // Pacing knobs, set by the stimulus process.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int holds_asked   = 0;

  logic pixel_taken = 1'b0;
  int   mismatches  = 0;
  int   pixels_in   = 0;
  int   results_out = 0;
  int   chroma_seen = 0;
  int   frames_seen = 0;
  int   settings    = 0;

  function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Drop the Q16 fraction; negative gives 0, saturate at 255.
  function automatic logic [7:0] q16_to_byte(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc >>> 16;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Convert one pixel at the current scan position and advance the position.
  function automatic yuv_result_t convert_pixel(input logic [23:0] pix);
    yuv_result_t res;
    int w, h, r, g, b, x, y, row, nxt;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    r = pix[7:0];
    g = pix[15:8];
    b = pix[23:16];
    // A resize may leave a counter past the new size: restart it.
    x   = (scan_col >= w) ? 0 : scan_col;
    row = (scan_row >= h) ? 0 : scan_row;
    // Bitmap rows come bottom-up, so flip to the image row.
    y = h - 1 - row;
    res.luma      = q16_to_byte(YR * r + YG * g + YB * b + Q16_HALF);
    res.luma_addr = 24'(y * w + x);
    res.chroma_valid = (x % 2 == 0) && (y % 2 == 0) && (x + 1 < w) && (y + 1 < h);
    if (res.chroma_valid) begin
      res.chroma_u    = q16_to_byte(UR * r + UG * g + UB * b + CHROMA_OFFS);
      res.chroma_v    = q16_to_byte(VR * r + VG * g + VB * b + CHROMA_OFFS);
      res.chroma_addr = 22'((y / 2) * (w / 2) + x / 2);
    end else begin
      res.chroma_u    = '0;
      res.chroma_v    = '0;
      res.chroma_addr = '0;
    end
    res.frame_end = (x + 1 == w) && (row + 1 == h);
    nxt = x + 1;
    if (nxt >= w) begin
      nxt = 0;
      row = row + 1;
      if (row >= h) row = 0;
    end
    scan_col = 12'(nxt);
    scan_row = 12'(row);
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: predict each accepted pixel request, then check each accepted result.
  always @(posedge clk) begin
    yuv_result_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        yuv_expected.push_back(convert_pixel(s_tdata));
        pixels_in++;
      end
      if (m_tvalid && m_tready) begin
        results_out++;
        if (m_tuser) chroma_seen++;
        if (m_tlast) frames_seen++;
        if (yuv_expected.size() == 0) begin
          $display("%0t: unexpected result: expected none, got tdata=%h tuser=%b tlast=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = yuv_expected.pop_front();
          check_field("luma",           want.luma,         m_tdata[7:0]);
          check_field("luma_address",   want.luma_addr,    m_tdata[31:8]);
          check_field("chroma_u",       want.chroma_u,     m_tdata[39:32]);
          check_field("chroma_v",       want.chroma_v,     m_tdata[47:40]);
          check_field("chroma_address", want.chroma_addr,  m_tdata[69:48]);
          check_field("tdata padding",  32'd0,             m_tdata[71:70]);
          check_field("chroma_valid",   want.chroma_valid, m_tuser);
          check_field("frame_end",      want.frame_end,    m_tlast);
        end
      end
    end
  end

  // Driver: hold a request until taken, then idle in a burst or present the next.
  int src_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !pixel_taken) begin
      // hold the request as it is
    end else if (src_gap > 0) begin
      src_gap--;
      s_tvalid <= 1'b0;
    end else if (pixel_q.size() > 0) begin
      s_tdata  <= pixel_q.pop_front();
      s_tvalid <= 1'b1;
      if ($urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 7);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Sink: a long hold-off when asked, otherwise random stall bursts.
  int sink_gap    = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < sink_idle_pct) sink_gap = $urandom_range(1, 7);
    end
  end

  // Watchdog: end the run when no request moves for too long.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, yuv_expected.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_size_reg(input ryuv_pkg::cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ryuv_pkg::REG_FRAME_WIDTH) width_reg = value[CFG_W-1:0];
    else height_reg = value[CFG_W-1:0];
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_q.push_back({b, g, r});
  endtask

  // Wait until every request is through the block and every expected result is checked.
  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid || yuv_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly tiny frames so that frames complete often; now and then zero or oversize.
  function automatic int pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return MAX_W;
      2:       return $urandom_range(MAX_W + 1, (1 << CFG_W) - 1);
      3, 4:    return $urandom_range(10, 40);
      default: return $urandom_range(1, 9);
    endcase
  endfunction

  function automatic int pick_idle();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(5, 40);
  endfunction

  initial begin
    int queued, n, area, phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset size 640x480: extremes of each channel.
    settings++;
    src_idle_pct  = pick_idle();
    sink_idle_pct = pick_idle();
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    drain();

    // Zero size reads as 1x1: every pixel ends a frame, never chroma.
    settings++;
    write_size_reg(ryuv_pkg::REG_FRAME_WIDTH, 0);
    write_size_reg(ryuv_pkg::REG_FRAME_HEIGHT, 0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd255);
    drain();

    // One whole 3x3 frame: one chroma sample, from a red pixel with V clamped high.
    settings++;
    write_size_reg(ryuv_pkg::REG_FRAME_WIDTH, 3);
    write_size_reg(ryuv_pkg::REG_FRAME_HEIGHT, 3);
    queue_pixel(8'd255, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd128, 8'd128);
    queue_pixel(8'd1, 8'd2, 8'd3);
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    drain();

    // Oversize saturates to the maximum: luma addresses in the last image row.
    settings++;
    write_size_reg(ryuv_pkg::REG_FRAME_WIDTH, (1 << CFG_W) - 1);
    write_size_reg(ryuv_pkg::REG_FRAME_HEIGHT, 5000);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    drain();

    // Shrink mid frame: the column counter sits past the new width and restarts.
    settings++;
    write_size_reg(ryuv_pkg::REG_FRAME_WIDTH, 2);
    write_size_reg(ryuv_pkg::REG_FRAME_HEIGHT, 4);
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    drain();

    // Random settings; sizes change between phases, often mid frame.
    queued = 0;
    phase  = 0;
    while (queued < RANDOM_PIX) begin
      settings++;
      phase++;
      if ($urandom_range(0, 3) != 0) write_size_reg(ryuv_pkg::REG_FRAME_WIDTH, pick_size());
      if ($urandom_range(0, 3) != 0) write_size_reg(ryuv_pkg::REG_FRAME_HEIGHT, pick_size());
      area = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
      if (area <= 100) n = $urandom_range(1, 2 * area + 3);
      else n = $urandom_range(1, 20);
      if (n > 90) n = 90;
      if (queued >= RANDOM_PIX - QUIET_TAIL) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = pick_idle();
        sink_idle_pct = pick_idle();
      end
      // Twice, back up the pipe: sink holds off while the sender keeps offering.
      if (phase == 2 || phase == 9) begin
        if (n < 30) n = 30;
        src_idle_pct = 0;
        holds_asked++;
      end
      repeat (n) queue_pixel(rand_chan(), rand_chan(), rand_chan());
      queued += n;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d pixels over %0d size settings, including zero and oversize",
             pixels_in, settings);
    $display("checked %0d results: %0d with chroma, %0d frame ends",
             results_out, chroma_seen, frames_seen);
    if (mismatches == 0 && yuv_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ryuv_pkg.sv
hw/rtl/ryuv_scan.sv
hw/rtl/ryuv_convert.sv
hw/rtl/rgb24_to_yuv420_bt601_unit.sv
test/testbench.sv
